// ===== rtl/isodr_pkg.sv =====
`timescale 1ns / 1ps
package isodr_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int ENTRY_CNT_W  = 9;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;
  localparam int ADDR_W       = 3;
  localparam int MAX_CHARS    = 3;

  localparam logic [7:0] MIN_RECORD   = 8'd34;
  localparam logic [7:0] NAME_LEN_POS = 8'd32;
  localparam logic [7:0] EXTENT_FIRST = 8'd6;
  localparam logic [7:0] EXTENT_LAST  = 8'd9;
  localparam logic [7:0] LENGTH_FIRST = 8'd14;
  localparam logic [7:0] LENGTH_LAST  = 8'd17;
  localparam logic [7:0] FLAGS_POS    = 8'd25;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam int         FLAG_DIR_BIT = 1;

  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  localparam logic REG_UNICODE_NAMES = 1'b0;

  typedef struct packed {
    logic [1:0]                 n_chars;
    logic [MAX_CHARS-1:0][7:0]  chars;
    logic [7:0]                 char_index;
    logic                       has_entry;
    logic [31:0]                extent;
    logic [31:0]                length;
    logic [7:0]                 flags;
    logic [7:0]                 entry_index;
    logic                       table_full;
  } bundle_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

endpackage

// ===== rtl/isodr_front.sv =====
`timescale 1ns / 1ps
module isodr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              sector_last,
  input  logic              new_listing,
  input  logic              unicode_names,
  output logic              push,
  output isodr_pkg::bundle_t bundle
);
  import isodr_pkg::*;

  logic [7:0]             record_position, record_position_next;
  logic [7:0]             record_length, record_length_next;
  logic                   skip_to_sector_end, skip_to_sector_end_next;
  logic [31:0]            extent_acc, extent_acc_next;
  logic [31:0]            length_acc, length_acc_next;
  logic [7:0]             flags_held, flags_held_next;
  logic [7:0]             name_bytes, name_bytes_next;
  logic [7:0]             held0, held0_next;
  logic [7:0]             held1, held1_next;
  logic [1:0]             held_count, held_count_next;
  logic [ENTRY_CNT_W-1:0] entry_count, entry_count_next;
  logic [31:0]            current_dir_extent, current_dir_extent_next;
  logic                   current_dir_valid, current_dir_valid_next;

  bundle_t    bnd;
  logic [7:0] pos;
  logic [8:0] j9;
  logic       go;
  logic       ends;
  logic       special;
  logic       is_dir;
  logic       cap_ok;
  logic [1:0] nc;

  always_comb begin
    record_position_next    = record_position;
    record_length_next      = record_length;
    skip_to_sector_end_next = skip_to_sector_end;
    extent_acc_next         = extent_acc;
    length_acc_next         = length_acc;
    flags_held_next         = flags_held;
    name_bytes_next         = name_bytes;
    held0_next              = held0;
    held1_next              = held1;
    held_count_next         = held_count;
    entry_count_next        = entry_count;
    current_dir_extent_next = current_dir_extent;
    current_dir_valid_next  = current_dir_valid;
    bnd     = '0;
    pos     = '0;
    j9      = '0;
    go      = 1'b0;
    ends    = 1'b0;
    special = 1'b0;
    is_dir  = flags_held[FLAG_DIR_BIT];
    cap_ok  = 1'b0;
    nc      = '0;

    if (new_listing) begin
      entry_count_next        = '0;
      record_position_next    = '0;
      record_length_next      = '0;
      skip_to_sector_end_next = 1'b0;
      held_count_next         = '0;
    end

    if (skip_to_sector_end_next) begin
      if (sector_last) begin
        skip_to_sector_end_next = 1'b0;
        record_position_next    = '0;
      end
    end else begin
      pos = record_position_next;
      go  = 1'b1;
      if (pos == 8'd0) begin
        record_length_next = data_byte;
        if (data_byte < MIN_RECORD) begin
          if (!sector_last) begin
            skip_to_sector_end_next = 1'b1;
          end
          go = 1'b0;
        end
      end
      if (go) begin
        ends = sector_last || (({1'b0, pos} + 9'd1) == {1'b0, record_length_next});

        if (pos >= EXTENT_FIRST && pos <= EXTENT_LAST) begin
          extent_acc_next = {extent_acc[23:0], data_byte};
        end else if (pos >= LENGTH_FIRST && pos <= LENGTH_LAST) begin
          length_acc_next = {length_acc[23:0], data_byte};
        end else if (pos == FLAGS_POS) begin
          flags_held_next = data_byte;
        end else if (pos == NAME_LEN_POS) begin
          name_bytes_next = data_byte;
          held_count_next = '0;
        end
        is_dir = flags_held_next[FLAG_DIR_BIT];

        if (pos >= NAME_LEN_POS &&
            {1'b0, pos} <= ({1'b0, NAME_LEN_POS} + {1'b0, name_bytes_next})) begin
          bnd.char_index = entry_count_next[7:0];
          if (pos > NAME_LEN_POS) begin
            j9 = {1'b0, pos} - {1'b0, NAME_LEN_POS} - 9'd1;
            cap_ok = entry_count_next < ENTRY_CNT_W'(MAX_ENTRIES);
            if (name_bytes_next == 8'd1 && j9 == 9'd0 && data_byte <= 8'd1) begin
              special = 1'b1;
              if (data_byte == 8'd0) begin
                current_dir_extent_next = extent_acc_next;
                current_dir_valid_next  = 1'b1;
              end else if (!current_dir_valid_next ||
                           current_dir_extent_next != extent_acc_next) begin
                bnd.has_entry = 1'b1;
                bnd.extent    = extent_acc_next;
                bnd.length    = length_acc_next;
                bnd.flags     = flags_held_next;
                if (!cap_ok) begin
                  bnd.table_full = 1'b1;
                end else begin
                  bnd.entry_index  = entry_count_next[7:0];
                  entry_count_next = entry_count_next + ENTRY_CNT_W'(1);
                end
              end
            end else if (cap_ok && (!unicode_names || j9[0])) begin
              if (is_dir) begin
                bnd.chars[nc] = data_byte;
                nc = nc + 2'd1;
              end else if (held_count_next == 2'd2) begin
                bnd.chars[nc] = held0_next;
                nc = nc + 2'd1;
                held0_next = held1_next;
                held1_next = data_byte;
              end else begin
                if (held_count_next == 2'd0) begin
                  held0_next = data_byte;
                end else begin
                  held1_next = data_byte;
                end
                held_count_next = held_count_next + 2'd1;
              end
            end
          end

          if (!special &&
              (({1'b0, pos} == ({1'b0, NAME_LEN_POS} + {1'b0, name_bytes_next})) || ends)) begin
            if (entry_count_next < ENTRY_CNT_W'(MAX_ENTRIES)) begin
              if (is_dir) begin
                bnd.chars[nc] = CHAR_SLASH;
                nc = nc + 2'd1;
              end else if (!(held_count_next == 2'd2 && held0_next == CHAR_SEMI)) begin
                if (held_count_next != 2'd0) begin
                  bnd.chars[nc] = held0_next;
                  nc = nc + 2'd1;
                end
                if (held_count_next == 2'd2) begin
                  bnd.chars[nc] = held1_next;
                  nc = nc + 2'd1;
                end
              end
            end
            held_count_next = '0;
            bnd.has_entry = 1'b1;
            bnd.extent    = extent_acc_next;
            bnd.length    = length_acc_next;
            bnd.flags     = flags_held_next;
            if (entry_count_next >= ENTRY_CNT_W'(MAX_ENTRIES)) begin
              bnd.table_full = 1'b1;
            end else begin
              bnd.entry_index  = entry_count_next[7:0];
              entry_count_next = entry_count_next + ENTRY_CNT_W'(1);
            end
          end
        end

        record_position_next = ends ? 8'd0 : pos + 8'd1;
      end
    end
    bnd.n_chars = nc;
  end

  assign bundle = bnd;
  assign push   = accept && (bnd.has_entry || bnd.n_chars != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_position    <= '0;
      record_length      <= '0;
      skip_to_sector_end <= 1'b0;
      extent_acc         <= '0;
      length_acc         <= '0;
      flags_held         <= '0;
      name_bytes         <= '0;
      held0              <= '0;
      held1              <= '0;
      held_count         <= '0;
      entry_count        <= '0;
      current_dir_extent <= '0;
      current_dir_valid  <= 1'b0;
    end else if (accept) begin
      record_position    <= record_position_next;
      record_length      <= record_length_next;
      skip_to_sector_end <= skip_to_sector_end_next;
      extent_acc         <= extent_acc_next;
      length_acc         <= length_acc_next;
      flags_held         <= flags_held_next;
      name_bytes         <= name_bytes_next;
      held0              <= held0_next;
      held1              <= held1_next;
      held_count         <= held_count_next;
      entry_count        <= entry_count_next;
      current_dir_extent <= current_dir_extent_next;
      current_dir_valid  <= current_dir_valid_next;
    end
  end

endmodule

// ===== rtl/isodr_queue.sv =====
`timescale 1ns / 1ps
module isodr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  isodr_pkg::bundle_t wr_bundle,
  input  logic               pop,
  output isodr_pkg::bundle_t head,
  output isodr_pkg::qstat_t  status
);
  import isodr_pkg::*;

  bundle_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign head         = slots[rptr];
  assign status.count = count;
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== rtl/isodr_back.sv =====
`timescale 1ns / 1ps
module isodr_back (
  input  logic               clk,
  input  logic               rst,
  input  isodr_pkg::bundle_t head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic [7:0]         name_char,
  output logic [31:0]        extent_sector,
  output logic [31:0]        data_length,
  output logic [7:0]         file_flags,
  output logic [7:0]         entry_index,
  output logic               table_full,
  output logic               run_last
);
  import isodr_pkg::*;

  logic [1:0] sub;
  logic [2:0] total;
  logic       is_char;
  logic       taken;

  assign total     = {1'b0, head.n_chars} + {2'b00, head.has_entry};
  assign is_char   = sub < head.n_chars;
  assign out_valid = !empty;
  assign taken     = out_valid && !out_stall;
  assign run_last  = ({1'b0, sub} + 3'd1) == total;
  assign pop       = taken && run_last;

  assign result_kind   = is_char ? KIND_CHAR : KIND_ENTRY;
  assign name_char     = is_char ? head.chars[sub] : 8'd0;
  assign extent_sector = is_char ? 32'd0 : head.extent;
  assign data_length   = is_char ? 32'd0 : head.length;
  assign file_flags    = is_char ? 8'd0 : head.flags;
  assign entry_index   = is_char ? head.char_index : head.entry_index;
  assign table_full    = is_char ? 1'b0 : head.table_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (pop) begin
      sub <= '0;
    end else if (taken) begin
      sub <= sub + 2'd1;
    end
  end

endmodule

// ===== rtl/iso9660_dir_record_parser_core.sv =====
`timescale 1ns / 1ps
// ISO 9660 directory record parser with optional Joliet names.
// The input channel (in_valid, in_stall) takes one directory-sector byte per
// transaction, with sector_last on the final byte of each sector and
// new_listing on the first byte of a directory. The output channel
// (out_valid, out_stall) carries name characters and end-of-entry
// descriptors; run_last marks the last result caused by one input byte.
// A byte is parsed in the cycle it is accepted, and its results enter a
// four-deep queue, from which they reach the output after the results
// queued ahead of them. One byte is accepted every cycle while the queue
// has room. The output side drains one result per cycle while out_stall
// is low; a byte that ends a name can cause up to four results, and the
// queue depth sets how many such runs it absorbs before in_stall rises.
// When the receiver stalls, the current result holds and the queue fills;
// in_stall is high exactly while the queue is full.
// The APB register at address 0, bit 0, selects Joliet names. Reset clears
// the parser state, the queue and that register at the next rising edge.
module iso9660_dir_record_parser_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         sector_last,
  input  logic                         new_listing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         result_kind,
  output logic [7:0]                   name_char,
  output logic [31:0]                  extent_sector,
  output logic [31:0]                  data_length,
  output logic [7:0]                   file_flags,
  output logic [7:0]                   entry_index,
  output logic                         table_full,
  output logic                         run_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [isodr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import isodr_pkg::*;

  logic    unicode_names;
  logic    accept;
  logic    push;
  logic    pop;
  bundle_t wr_bundle;
  bundle_t head;
  qstat_t  qstat;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_UNICODE_NAMES) ? {31'd0, unicode_names} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unicode_names <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1] == REG_UNICODE_NAMES) begin
      unicode_names <= pwdata[0];
    end
  end

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  isodr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .sector_last   (sector_last),
    .new_listing   (new_listing),
    .unicode_names (unicode_names),
    .push          (push),
    .bundle        (wr_bundle)
  );

  isodr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .head      (head),
    .status    (qstat)
  );

  isodr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (qstat.empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .name_char     (name_char),
    .extent_sector (extent_sector),
    .data_length   (data_length),
    .file_flags    (file_flags),
    .entry_index   (entry_index),
    .table_full    (table_full),
    .run_last      (run_last)
  );

`ifndef SYNTHESIS
  a_full_only_entry : assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (result_kind == KIND_ENTRY && entry_index == 8'd0))
    else $error("table_full set on a result that is not a dropped descriptor");

  a_char_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_CHAR) |->
      (extent_sector == 32'd0 && data_length == 32'd0 && file_flags == 8'd0))
    else $error("character result carries descriptor fields");

  a_burst_continues : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !run_last) |=> out_valid)
    else $error("result run ended without run_last");

  a_stall_when_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (qstat.count == QCNT_W'(QUEUE_DEPTH) && out_valid))
    else $error("input stalled while the queue has room");
`endif

endmodule

// ===== dv/tb_iso9660_dir_record_parser_core.sv =====
`timescale 1ns / 1ps
module tb_iso9660_dir_record_parser_core;
  import isodr_pkg::*;

  typedef bit [7:0] byte_q_t[$];

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [31:0] ext;
    logic [31:0] dlen;
    logic [7:0]  flg;
    logic [7:0]  idx;
    logic        full;
    logic        run_end;
  } dir_result_t;

  localparam logic [ADDR_W-1:0] UNICODE_ADDR = ADDR_W'(4 * int'(REG_UNICODE_NAMES));

  class record_parse_scoreboard;
    bit          unicode;
    bit [7:0]    rec_pos;
    bit [7:0]    rec_len;
    bit          skipping;
    bit [31:0]   ext_acc;
    bit [31:0]   len_acc;
    bit [7:0]    flags;
    bit [7:0]    name_len;
    bit [7:0]    held[2];
    int          held_n;
    int          entries;
    bit [31:0]   cur_dir;
    bit          cur_dir_ok;
    dir_result_t step_results[$];
    dir_result_t pending_results[$];
    int          failures;

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function string show(dir_result_t r);
      return $sformatf({"kind=%0d char=%02h extent=%08h length=%08h flags=%02h",
                        " index=%0d full=%0d run_last=%0d"},
                       r.kind, r.ch, r.ext, r.dlen, r.flg, r.idx, r.full, r.run_end);
    endfunction

    function void add_char(bit [7:0] c);
      step_results.push_back('{kind: KIND_CHAR, ch: c, ext: 32'd0, dlen: 32'd0, flg: 8'd0,
                               idx: 8'(entries), full: 1'b0, run_end: 1'b0});
    endfunction

    function void add_entry();
      if (entries >= MAX_ENTRIES) begin
        step_results.push_back('{kind: KIND_ENTRY, ch: 8'd0, ext: ext_acc, dlen: len_acc,
                                 flg: flags, idx: 8'd0, full: 1'b1, run_end: 1'b0});
      end else begin
        step_results.push_back('{kind: KIND_ENTRY, ch: 8'd0, ext: ext_acc, dlen: len_acc,
                                 flg: flags, idx: 8'(entries), full: 1'b0, run_end: 1'b0});
        entries++;
      end
    endfunction

    // Works out the results that one accepted byte causes and queues them.
    function void note_byte(bit [7:0] b, bit last, bit fresh);
      int pos;
      int j;
      int i;
      int name_end;
      bit ends;
      bit special;
      step_results.delete();
      if (fresh) begin
        entries = 0;
        rec_pos = 0;
        rec_len = 0;
        skipping = 0;
        held_n = 0;
      end
      if (skipping) begin
        if (last) begin
          skipping = 0;
          rec_pos = 0;
        end
        return;
      end
      pos = int'(rec_pos);
      if (pos == 0) begin
        rec_len = b;
        if (b < MIN_RECORD) begin
          if (!last) skipping = 1;
          return;
        end
      end
      ends = last || (pos + 1 == int'(rec_len));

      if (pos >= int'(EXTENT_FIRST) && pos <= int'(EXTENT_LAST)) begin
        ext_acc = {ext_acc[23:0], b};
      end else if (pos >= int'(LENGTH_FIRST) && pos <= int'(LENGTH_LAST)) begin
        len_acc = {len_acc[23:0], b};
      end else if (pos == int'(FLAGS_POS)) begin
        flags = b;
      end else if (pos == int'(NAME_LEN_POS)) begin
        name_len = b;
        held_n = 0;
      end

      name_end = int'(NAME_LEN_POS) + int'(name_len);
      if (pos >= int'(NAME_LEN_POS) && pos <= name_end) begin
        special = 0;
        if (pos > int'(NAME_LEN_POS)) begin
          j = pos - int'(NAME_LEN_POS) - 1;
          if (name_len == 8'd1 && j == 0 && b <= 8'd1) begin
            special = 1;
            if (b == 8'd0) begin
              cur_dir = ext_acc;
              cur_dir_ok = 1;
            end else if (!cur_dir_ok || cur_dir != ext_acc) begin
              add_entry();
            end
          end else if (entries < MAX_ENTRIES && (!unicode || j[0])) begin
            // A file name holds back its last two characters for the version check.
            if (flags[FLAG_DIR_BIT]) begin
              add_char(b);
            end else if (held_n >= 2) begin
              add_char(held[0]);
              held[0] = held[1];
              held[1] = b;
            end else begin
              held[held_n] = b;
              held_n++;
            end
          end
        end
        if (!special && (pos == name_end || ends)) begin
          if (entries < MAX_ENTRIES) begin
            if (flags[FLAG_DIR_BIT]) begin
              add_char(CHAR_SLASH);
            end else if (!(held_n == 2 && held[0] == CHAR_SEMI)) begin
              for (i = 0; i < held_n; i++) add_char(held[i]);
            end
          end
          held_n = 0;
          add_entry();
        end
      end

      rec_pos = ends ? 8'd0 : 8'(pos + 1);
      if (step_results.size() > 0) step_results[step_results.size() - 1].run_end = 1'b1;
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    endfunction

    function void check_result(dir_result_t got);
      dir_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("Unexpected result: %s", show(got)));
        return;
      end
      want = pending_results.pop_front();
      if (got !== want)
        report($sformatf("Result mismatch: expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              sector_last;
  logic              new_listing;
  logic              out_valid;
  logic              out_stall;
  logic              result_kind;
  logic [7:0]        name_char;
  logic [31:0]       extent_sector;
  logic [31:0]       data_length;
  logic [7:0]        file_flags;
  logic [7:0]        entry_index;
  logic              table_full;
  logic              run_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  record_parse_scoreboard sb = new();
  bit        in_quiet;
  bit        out_quiet;
  bit [31:0] dot_extent;
  int        bytes_sent;

  iso9660_dir_record_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .sector_last(sector_last), .new_listing(new_listing),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .name_char(name_char), .extent_sector(extent_sector),
    .data_length(data_length), .file_flags(file_flags), .entry_index(entry_index),
    .table_full(table_full), .run_last(run_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait(bit quiet);
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic bit [31:0] field_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic byte_q_t single(bit [7:0] b);
    byte_q_t r;
    r.push_back(b);
    return r;
  endfunction

  function automatic byte_q_t name_of(string s, bit joliet);
    byte_q_t r;
    for (int i = 0; i < s.len(); i++) begin
      if (joliet) r.push_back(8'h00);
      r.push_back(s[i]);
    end
    return r;
  endfunction

  function automatic byte_q_t build_name(int nlen, bit joliet, bit version);
    bit [7:0] chars[$];
    byte_q_t  r;
    int       nchars;
    nchars = joliet ? nlen / 2 : nlen;
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(0, 9) == 0) chars.push_back(8'($urandom));
      else if ($urandom_range(0, 14) == 0) chars.push_back(CHAR_SEMI);
      else chars.push_back(8'h41 + 8'($urandom_range(0, 25)));
    end
    if (version && nchars >= 2) begin
      chars[nchars - 2] = CHAR_SEMI;
      chars[nchars - 1] = 8'h30 + 8'($urandom_range(0, 9));
    end
    for (int i = 0; i < nlen; i++) begin
      if (!joliet) r.push_back(chars[i]);
      else if (i % 2 == 1) r.push_back(chars[i / 2]);
      else r.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
    end
    return r;
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit last, input bit fresh);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    sector_last <= last;
    new_listing <= fresh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, last, fresh);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_unicode(input bit v);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= UNICODE_ADDR;
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.unicode = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== v)
      sb.report($sformatf("Register readback mismatch: expected %0d, got %0h", v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sends a directory record; a nonzero cut ends the sector after that many bytes.
  task automatic send_record(input int rl, input bit [31:0] ext, input bit [31:0] dlen,
                             input bit [7:0] flg, input byte_q_t name, input int cut,
                             input bit fresh);
    int       total;
    int       nlen;
    bit [7:0] b;
    nlen = name.size();
    if (rl == 0) rl = (33 + nlen < 34) ? 34 : 33 + nlen;
    total = (cut > 0) ? cut : rl;
    for (int p = 0; p < total; p++) begin
      if (p == 0) b = 8'(rl);
      else if (p >= 6 && p <= 9) b = 8'(ext >> (8 * (9 - p)));
      else if (p >= 14 && p <= 17) b = 8'(dlen >> (8 * (17 - p)));
      else if (p == int'(FLAGS_POS)) b = flg;
      else if (p == int'(NAME_LEN_POS)) b = 8'(nlen);
      else if (p >= 33 && p < 33 + nlen) b = name[p - 33];
      else b = 8'($urandom);
      send_byte(b, (cut > 0) && (p == total - 1), fresh && (p == 0));
    end
  endtask

  task automatic fill_sector(input int n);
    for (int i = 0; i < n; i++)
      send_byte((i == 0) ? 8'd0 : 8'($urandom), i == n - 1, 1'b0);
  endtask

  task automatic random_record(input bit joliet, input bit allow_fresh);
    int        k;
    int        nlen;
    int        rl;
    int        cut;
    int        nfill;
    int        r;
    bit [31:0] ext;
    bit [31:0] dlen;
    bit [7:0]  flg;
    bit        fresh;
    bit        is_dir;
    fresh  = allow_fresh && ($urandom_range(0, 19) == 0);
    ext    = field_value();
    dlen   = field_value();
    is_dir = ($urandom_range(0, 9) < 3);
    flg    = 8'($urandom);
    flg[FLAG_DIR_BIT] = is_dir;
    if ($urandom_range(0, 11) == 0) in_quiet = !in_quiet;
    if ($urandom_range(0, 11) == 0) out_quiet = !out_quiet;
    if ($urandom_range(0, 39) == 0) wait_idle();
    k = $urandom_range(0, 99);
    if (k < 8) begin
      dot_extent = ext;
      send_record(34, ext, dlen, flg, single(8'h00), 0, fresh);
    end else if (k < 16) begin
      if ($urandom_range(0, 1)) ext = dot_extent;
      send_record(34, ext, dlen, flg, single(8'h01), 0, fresh);
    end else if (k < 22) begin
      nfill = $urandom_range(0, 4);
      send_byte(8'($urandom_range(0, 33)), nfill == 0, fresh);
      if (nfill > 0) fill_sector(nfill);
    end else if (k < 25) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 3) == 0, fresh);
      fill_sector($urandom_range(1, 3));
    end else begin
      r = $urandom_range(0, 19);
      nlen = (r == 0) ? 0 : (r == 1) ? $urandom_range(100, 222) : $urandom_range(1, 14);
      rl = 33 + nlen + $urandom_range(0, 3);
      if (rl > 255) rl = 255;
      if (rl < 34) rl = 34;
      cut = 0;
      case ($urandom_range(0, 9))
        0: cut = $urandom_range(1, rl - 1);
        1: if (nlen >= 3) rl = $urandom_range(34, 32 + nlen);
        default: ;
      endcase
      send_record(rl, ext, dlen, flg,
                  build_name(nlen, joliet, !is_dir && $urandom_range(0, 1)), cut, fresh);
    end
    if ($urandom_range(0, 9) == 0) fill_sector($urandom_range(1, 5));
  endtask

  initial begin
    int pause;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      pause = draw_wait(out_quiet);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result('{kind: result_kind, ch: name_char, ext: extent_sector,
                        dlen: data_length, flg: file_flags, idx: entry_index,
                        full: table_full, run_end: run_last});
    end
  end

  initial begin
    #200_000_000;
    $display("[iso9660_dir_record_parser_core] ERROR");
    $finish;
  end

  initial begin
    int start;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    data_byte   <= 8'd0;
    sector_last <= 1'b0;
    new_listing <= 1'b0;
    out_stall   <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= 32'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_unicode(1'b0);
    send_record(0, 32'h1234_5678, 32'h0000_0800, 8'h02, single(8'h01), 0, 1'b1);
    send_record(0, 32'h1234_5678, 32'h0000_0800, 8'h02, single(8'h00), 0, 1'b0);
    send_record(0, 32'h1234_5678, 32'h0000_0800, 8'h02, single(8'h01), 0, 1'b0);
    send_record(0, 32'd0, 32'd0, 8'h00, name_of("AB;1", 0), 0, 1'b0);
    send_record(0, 32'd7, 32'd1, 8'hFD, name_of(";", 0), 0, 1'b0);
    send_record(0, 32'd9, 32'd3, 8'h02, name_of("DIR", 0), 0, 1'b0);
    send_byte(8'd33, 1'b0, 1'b0);
    fill_sector(3);

    set_unicode(1'b1);
    send_record(0, 32'd20, 32'd100, 8'h00, name_of("README.TXT;1", 1), 0, 1'b0);
    start = bytes_sent;
    while (bytes_sent - start < 80) random_record(1'b1, 1'b1);

    set_unicode(1'b0);
    start = bytes_sent;
    while (bytes_sent - start < 80) random_record(1'b0, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("[iso9660_dir_record_parser_core] OK");
    end else begin
      $display("[iso9660_dir_record_parser_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/isodr_pkg.sv
rtl/isodr_front.sv
rtl/isodr_queue.sv
rtl/isodr_back.sv
rtl/iso9660_dir_record_parser_core.sv
dv/tb_iso9660_dir_record_parser_core.sv
